/* rtl/pixel_stream_crc32_reflected_defines.svh */
// Assertion macros used by the pixel stream CRC top level.
`ifndef PIXEL_STREAM_CRC32_REFLECTED_DEFINES_SVH
`define PIXEL_STREAM_CRC32_REFLECTED_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSCRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pscrc_pkg.sv */
// Package: CRC constants and the elaboration-time fold matrix builder.
package pscrc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hD801_8001;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CRC_W    = 32;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CRC_W-1:0] crc_t;
  // one row per result bit, one column per input bit {pixel, crc}
  typedef logic [CRC_W-1:0][CRC_W+PIX_W-1:0] fold_mat_t;

  // Bit-serial fold of four bytes, low byte first; elaboration use only.
  function automatic crc_t fold_serial(crc_t crc, pixel_t pix);
    crc_t c;
    crc_t t;
    c = crc;
    for (int k = 0; k < 4; k++) begin
      t = {24'h0, c[7:0] ^ pix[8*k +: 8]};
      for (int b = 0; b < 8; b++) begin
        if (t[0]) t = (t >> 1) ^ CRC_POLY;
        else      t = t >> 1;
      end
      c = t ^ (c >> 8);
    end
    return c;
  endfunction

  // The fold is linear over GF(2): build it from unit vectors.
  function automatic fold_mat_t build_fold_mat();
    fold_mat_t m;
    crc_t      col;
    crc_t      c_in;
    pixel_t    p_in;
    m = '0;
    for (int i = 0; i < CRC_W + PIX_W; i++) begin
      c_in = '0;
      p_in = '0;
      if (i < CRC_W) c_in[i] = 1'b1;
      else           p_in[i-CRC_W] = 1'b1;
      col = fold_serial(c_in, p_in);
      for (int j = 0; j < CRC_W; j++) m[j][i] = col[j];
    end
    return m;
  endfunction

endpackage

/* rtl/pscrc_fold.sv */
// Parallel XOR network folding one 32-bit pixel into the running CRC.
module pscrc_fold (
  input  pscrc_pkg::crc_t   crc_i,
  input  pscrc_pkg::pixel_t pix_i,
  output pscrc_pkg::crc_t   crc_o
);
  import pscrc_pkg::*;

  localparam fold_mat_t FOLD_MAT = build_fold_mat();

  logic [CRC_W+PIX_W-1:0] vec;

  assign vec = {pix_i, crc_i};

  always_comb begin
    for (int j = 0; j < CRC_W; j++) begin
      crc_o[j] = ^(FOLD_MAT[j] & vec);
    end
  end

endmodule

/* rtl/pixel_stream_crc32_reflected.sv */
// Pixel stream reflected CRC-32 hasher: top level with input and result registers.
//
// Input channel in_*: one 32-bit pixel per word on in_tdata (byte at the lowest
// address in bits 7:0, folded first). in_tlast marks the final pixel of a
// rectangle; in_tuser set marks an empty rectangle, its pixel and tlast ignored.
// Result channel out_*: one 32-bit hash per rectangle on out_tdata, 0 for an
// empty rectangle. Pixels that are not last produce no result word.
// Reversed polynomial 0xD8018001, start value all ones, no final inversion.
// Path: the last pixel passes the input register, then the result register,
// before its hash is on out_tdata.
// Throughput: one word per cycle while no result is blocked; the fold of all four bytes is a single XOR
// network between the input register and the running CRC / result register.
// Reset (rst_n low, synchronous) empties both stages and loads all ones into
// the running CRC. When the receiver stalls, the result is held; the input
// stage keeps taking non-last pixels and stops only once a result is blocked.
module pixel_stream_crc32_reflected (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  pscrc_pkg::pixel_t        in_tdata,   // [31:0] pixel
  input  logic                     in_tlast,   // last
  input  logic                     in_tuser,   // [0] empty_req
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output pscrc_pkg::crc_t          out_tdata   // [31:0] hash
);
  import pscrc_pkg::*;
`include "pixel_stream_crc32_reflected_defines.svh"

  logic   s1_v_r;
  pixel_t s1_pix_r;
  logic   s1_last_r;
  logic   s1_empty_r;
  crc_t   crc_r;
  crc_t   crc_nxt;
  crc_t   folded;
  logic   out_v_r;
  crc_t   out_data_r;

  logic   out_free;
  logic   s1_emit;
  logic   s1_adv;
  logic   in_acc;

  pscrc_fold u_fold (
    .crc_i (crc_r),
    .pix_i (s1_pix_r),
    .crc_o (folded)
  );

  assign out_free  = !out_v_r || out_tready;
  assign s1_emit   = s1_last_r || s1_empty_r;
  assign s1_adv    = s1_v_r && (!s1_emit || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    crc_nxt = crc_r;
    if (s1_adv) begin
      if (s1_emit) crc_nxt = CRC_INIT;
      else         crc_nxt = folded;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
    if (in_acc) begin
      s1_pix_r   <= in_tdata;
      s1_last_r  <= in_tlast;
      s1_empty_r <= in_tuser;
    end
  end

  // running CRC and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      out_v_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      if (s1_adv && s1_emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
    if (s1_adv && s1_emit) begin
      out_data_r <= s1_empty_r ? '0 : folded;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `PSCRC_ASSERT_NEXT(a_empty_gives_zero, s1_adv && s1_empty_r, out_v_r && (out_data_r == '0), "empty rectangle did not give a zero hash")
  `PSCRC_ASSERT_NEXT(a_crc_reload, s1_adv && s1_emit, crc_r == CRC_INIT, "running CRC not reloaded after a result")
  `PSCRC_ASSERT_NEXT(a_crc_hold, !s1_adv, $stable(crc_r), "running CRC changed without an advancing word")
  `PSCRC_ASSERT_SAME(a_ready_when_free, !s1_v_r, in_tready, "input stage empty but not ready")

endmodule

/* test/tb_pixel_stream_crc32_reflected.sv */
// Testbench for the pixel stream reflected CRC-32 hasher.
`timescale 1ns / 1ps

module tb_pixel_stream_crc32_reflected;

  import pscrc_pkg::*;

  typedef struct packed {
    pixel_t pixel;
    logic   last;
    logic   empty;
  } pixel_word_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_tvalid = 1'b0;
  logic   in_tready;
  pixel_t in_tdata = '0;
  logic   in_tlast = 1'b0;
  logic   in_tuser = 1'b0;
  logic   out_tvalid;
  logic   out_tready = 1'b0;
  crc_t   out_tdata;

  pixel_word_t pixel_words_q[$];
  crc_t        hash_expected_q[$];
  crc_t        crc_running;
  int          mismatches = 0;
  int          hashes_seen = 0;
  int unsigned cyc = 0;
  logic        hold_off = 1'b0;
  logic        calm;

  pixel_stream_crc32_reflected uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;
  // window with no random idling on either side
  assign calm = (cyc >= 600) && (cyc < 900);

  // Reflected CRC, one pixel bit at a time, bit 0 of the pixel first.
  function automatic crc_t crc_fold_pixel(crc_t crc, pixel_t pix);
    crc_t c;
    c = crc;
    for (int i = 0; i < PIX_W; i++) begin
      if (c[0] ^ pix[i]) c = (c >> 1) ^ CRC_POLY;
      else               c = c >> 1;
    end
    return c;
  endfunction

  task automatic add_word(pixel_t pix, logic last, logic empty);
    pixel_word_t w;
    w.pixel = pix;
    w.last  = last;
    w.empty = empty;
    pixel_words_q.push_back(w);
  endtask

  // Driver: predicts on each accepted word, then offers the next one.
  always @(posedge clk) begin : driver
    pixel_word_t w;
    crc_t        c;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      crc_running = CRC_INIT;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          hash_expected_q.push_back('0);
          crc_running = CRC_INIT;
        end else begin
          c = crc_fold_pixel(crc_running, in_tdata);
          if (in_tlast) begin
            hash_expected_q.push_back(c);
            crc_running = CRC_INIT;
          end else begin
            crc_running = c;
          end
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pixel_words_q.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
          w = pixel_words_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= w.pixel;
          in_tlast  <= w.last;
          in_tuser  <= w.empty;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= !hold_off && (calm || $urandom_range(99) >= 36);
  end

  // Monitor: each accepted hash against the oldest expectation.
  always @(posedge clk) begin : monitor
    crc_t exp_hash;
    if (rst_n && out_tvalid && out_tready) begin
      hashes_seen <= hashes_seen + 1;
      if (hash_expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected hash word %08h", out_tdata);
      end else begin
        exp_hash = hash_expected_q.pop_front();
        if (out_tdata !== exp_hash) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("hash mismatch: expected %08h, got %08h", exp_hash, out_tdata);
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up and drops in_tready.
  initial begin
    while (hashes_seen < 20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int n_words;
    int len;
    int r;
    pixel_t pix;

    // directed: empties, single-pixel frames, byte order, partial frame discard
    add_word(32'h0000_0000, 1'b0, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    add_word(32'h0000_0000, 1'b1, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_word(32'h0000_00FF, 1'b1, 1'b0);
    add_word(32'hFF00_0000, 1'b1, 1'b0);
    add_word(32'h0123_4567, 1'b0, 1'b0);
    add_word(32'h89AB_CDEF, 1'b0, 1'b0);
    add_word(32'hDEAD_BEEF, 1'b1, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_word(32'h5555_AAAA, 1'b0, 1'b0);
    add_word(32'hA5A5_A5A5, 1'b0, 1'b1);
    add_word(32'h1234_5678, 1'b1, 1'b0);
    add_word(32'h8000_0000, 1'b0, 1'b0);
    add_word(32'h0000_0001, 1'b0, 1'b0);
    add_word(32'h0000_0000, 1'b0, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_word(32'hAAAA_AAAA, 1'b1, 1'b1);
    add_word(32'h5555_5555, 1'b1, 1'b0);
    n_words = 19;

    // random: mostly frames of random length, some empties and cut-off frames
    while (n_words < 500) begin
      r = $urandom_range(99);
      if (r < 10) begin
        add_word($urandom, 1'($urandom_range(1)), 1'b1);
        n_words++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0:       pix = '0;
            1:       pix = '1;
            default: pix = $urandom;
          endcase
          if (i == len - 1 && r < 18) add_word($urandom, 1'($urandom_range(1)), 1'b1);
          else                        add_word(pix, i == len - 1, 1'b0);
          n_words++;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_words_q.size() != 0 || in_tvalid) @(posedge clk);
    while (hash_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* pixel_stream_crc32_reflected.f */
+incdir+rtl
rtl/pscrc_pkg.sv
rtl/pscrc_fold.sv
rtl/pixel_stream_crc32_reflected.sv
test/tb_pixel_stream_crc32_reflected.sv
